@@ design/mcsp_pkg.sv @@
`timescale 1ns / 1ps

package mcsp_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 16;

  localparam logic [7:0] PULSE_WIDTH_RST = 8'd5;
  localparam logic [6:0] PULSES_PER_BEAT_RST = 7'd24;
  localparam logic [3:0] TIMEOUT_MULT_RST = 4'd3;

  typedef enum logic [1:0] {
    REQ_CLOCK = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_DIN  = 2'd1,
    SRC_USB  = 2'd2
  } master_t;

  typedef enum logic [1:0] {
    CFG_PULSE_WIDTH     = 2'd0,
    CFG_PULSES_PER_BEAT = 2'd1,
    CFG_TIMEOUT_MULT    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       source;
  } in_word_t;

  typedef struct packed {
    logic       sync_pulse;
    logic       beat_led;
    logic [1:0] master_source;
    logic       running;
    logic       usb_running;
    logic [6:0] beat_position;
  } out_word_t;

  typedef struct packed {
    logic [7:0] pulse_width_ticks;
    logic [6:0] pulses_per_beat;
    logic [3:0] timeout_multiplier;
  } cfg_t;

endpackage

@@ design/midi_clock_sync_pulse_out_unit.sv @@
`timescale 1ns / 1ps

// MIDI clock to sync-pulse converter. Each input word is one event (clock,
// start, stop from DIN or USB, or a 1 ms tick) and yields exactly one output
// word with the sync and beat LED levels, master source, play flags and the
// position within the beat. The block takes one word per clock cycle
// sustained while the output is ready. A word passes through the input
// register, and the state update logic then loads the result register. A
// stalled output holds the staged word and drops the input ready.
// Configuration writes are taken at any time on their own channel but must
// only be issued while no event is in flight.
module midi_clock_sync_pulse_out_unit #(
  parameter int unsigned TIME_WIDTH = mcsp_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcsp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcsp_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  mcsp_pkg::cfg_t      cfg;
  mcsp_pkg::in_word_t  in_reg;
  logic                in_reg_valid;
  mcsp_pkg::out_word_t result;
  logic                advance;

  // The staged word is processed whenever the result register is free or drains.
  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  mcsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mcsp_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_reg),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

@@ design/mcsp_cfg_regs.sv @@
`timescale 1ns / 1ps

module mcsp_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output mcsp_pkg::cfg_t    cfg
);

  mcsp_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  // A write to an index past the register list is taken and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pulse_width_ticks  <= mcsp_pkg::PULSE_WIDTH_RST;
      regs.pulses_per_beat    <= mcsp_pkg::PULSES_PER_BEAT_RST;
      regs.timeout_multiplier <= mcsp_pkg::TIMEOUT_MULT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mcsp_pkg::CFG_PULSE_WIDTH:     regs.pulse_width_ticks  <= cfg_data;
        mcsp_pkg::CFG_PULSES_PER_BEAT: regs.pulses_per_beat    <= cfg_data[6:0];
        mcsp_pkg::CFG_TIMEOUT_MULT:    regs.timeout_multiplier <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/mcsp_core.sv @@
`timescale 1ns / 1ps

module mcsp_core #(
  parameter int unsigned TIME_WIDTH = mcsp_pkg::TIME_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  mcsp_pkg::in_word_t  item,
  input  mcsp_pkg::cfg_t      cfg,
  output mcsp_pkg::out_word_t result
);

  localparam int unsigned AW = TIME_WIDTH + 3;
  localparam int unsigned LW = TIME_WIDTH + 4;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  logic                  play_flag, play_flag_next;
  logic                  usb_play_flag, usb_play_flag_next;
  mcsp_pkg::master_t     master_reg, master_reg_next;
  logic [6:0]            pulse_count, pulse_count_next;
  logic                  pulse_level, pulse_level_next;
  logic                  led_level, led_level_next;
  logic [TIME_WIDTH-1:0] ticks_since_pulse, ticks_since_pulse_next;
  logic [TIME_WIDTH-1:0] ms_since_usb_clock, ms_since_usb_clock_next;
  logic                  prev_usb_valid, prev_usb_valid_next;
  logic [TIME_WIDTH-1:0] avg_usb_interval, avg_usb_interval_next;

  logic [AW-1:0]         avg_ext, iv_ext, avg_sum;
  logic [TIME_WIDTH-1:0] avg_blend;
  logic [TIME_WIDTH-1:0] ms_inc, ticks_inc;
  logic [LW-1:0]         timeout_limit;
  logic [6:0]            count_inc;
  logic                  is_usb;

  // Weighted average: (3 * old + 5 * new) / 8, never wider than the time width.
  assign avg_ext   = AW'(avg_usb_interval);
  assign iv_ext    = AW'(ms_since_usb_clock);
  assign avg_sum   = (avg_ext << 1) + avg_ext + (iv_ext << 2) + iv_ext;
  assign avg_blend = avg_sum[AW-1:3];

  assign ms_inc    = (ms_since_usb_clock == TIME_MAX) ? TIME_MAX : ms_since_usb_clock + 1'b1;
  assign ticks_inc = (ticks_since_pulse == TIME_MAX) ? TIME_MAX : ticks_since_pulse + 1'b1;

  assign timeout_limit = LW'(avg_usb_interval) * LW'(cfg.timeout_multiplier);
  assign count_inc     = pulse_count + 7'd1;
  assign is_usb        = item.source;

  always_comb begin
    play_flag_next          = play_flag;
    usb_play_flag_next      = usb_play_flag;
    master_reg_next         = master_reg;
    pulse_count_next        = pulse_count;
    pulse_level_next        = pulse_level;
    led_level_next          = led_level;
    ticks_since_pulse_next  = ticks_since_pulse;
    ms_since_usb_clock_next = ms_since_usb_clock;
    prev_usb_valid_next     = prev_usb_valid;
    avg_usb_interval_next   = avg_usb_interval;

    case (item.req_type)
      mcsp_pkg::REQ_CLOCK: begin
        if (is_usb && usb_play_flag) begin
          if (prev_usb_valid) begin
            avg_usb_interval_next = (avg_usb_interval == '0) ? ms_since_usb_clock
                                                              : avg_blend;
          end
          prev_usb_valid_next     = 1'b1;
          ms_since_usb_clock_next = '0;
          master_reg_next         = mcsp_pkg::SRC_USB;
        end
        // A DIN clock is dropped while USB holds mastership.
        if (is_usb || master_reg != mcsp_pkg::SRC_USB) begin
          if (!is_usb) begin
            master_reg_next = mcsp_pkg::SRC_DIN;
          end
          if (play_flag) begin
            pulse_level_next       = 1'b1;
            ticks_since_pulse_next = '0;
            if (pulse_count == 7'd0) begin
              led_level_next = 1'b1;
            end
            pulse_count_next = (count_inc >= cfg.pulses_per_beat) ? 7'd0 : count_inc;
          end
        end
      end
      mcsp_pkg::REQ_START: begin
        if (is_usb || !usb_play_flag) begin
          if (is_usb) begin
            usb_play_flag_next      = 1'b1;
            master_reg_next         = mcsp_pkg::SRC_USB;
            ms_since_usb_clock_next = '0;
            prev_usb_valid_next     = 1'b0;
            avg_usb_interval_next   = '0;
          end else begin
            master_reg_next = mcsp_pkg::SRC_DIN;
          end
          play_flag_next         = 1'b1;
          pulse_count_next       = 7'd0;
          pulse_level_next       = 1'b1;
          led_level_next         = 1'b1;
          ticks_since_pulse_next = '0;
        end
      end
      mcsp_pkg::REQ_STOP: begin
        if (is_usb) begin
          // USB stop hands back control but leaves the transport playing.
          usb_play_flag_next    = 1'b0;
          master_reg_next       = mcsp_pkg::SRC_NONE;
          avg_usb_interval_next = '0;
          prev_usb_valid_next   = 1'b0;
        end else if (!usb_play_flag) begin
          master_reg_next  = mcsp_pkg::SRC_NONE;
          play_flag_next   = 1'b0;
          pulse_count_next = 7'd0;
          pulse_level_next = 1'b0;
          led_level_next   = 1'b0;
        end
      end
      mcsp_pkg::REQ_TICK: begin
        ms_since_usb_clock_next = ms_inc;
        ticks_since_pulse_next  = ticks_inc;
        if (usb_play_flag && avg_usb_interval != '0 && LW'(ms_inc) > timeout_limit) begin
          usb_play_flag_next    = 1'b0;
          master_reg_next       = mcsp_pkg::SRC_NONE;
          avg_usb_interval_next = '0;
          prev_usb_valid_next   = 1'b0;
        end
        if (ticks_inc >= TIME_WIDTH'(cfg.pulse_width_ticks)) begin
          pulse_level_next = 1'b0;
          led_level_next   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_flag          <= 1'b0;
      usb_play_flag      <= 1'b0;
      master_reg         <= mcsp_pkg::SRC_NONE;
      pulse_count        <= 7'd0;
      pulse_level        <= 1'b0;
      led_level          <= 1'b0;
      ticks_since_pulse  <= '0;
      ms_since_usb_clock <= '0;
      prev_usb_valid     <= 1'b0;
      avg_usb_interval   <= '0;
    end else if (fire) begin
      play_flag          <= play_flag_next;
      usb_play_flag      <= usb_play_flag_next;
      master_reg         <= master_reg_next;
      pulse_count        <= pulse_count_next;
      pulse_level        <= pulse_level_next;
      led_level          <= led_level_next;
      ticks_since_pulse  <= ticks_since_pulse_next;
      ms_since_usb_clock <= ms_since_usb_clock_next;
      prev_usb_valid     <= prev_usb_valid_next;
      avg_usb_interval   <= avg_usb_interval_next;
    end
  end

  always_comb begin
    result.sync_pulse    = pulse_level_next;
    result.beat_led      = led_level_next;
    result.master_source = master_reg_next;
    result.running       = play_flag_next;
    result.usb_running   = usb_play_flag_next;
    result.beat_position = pulse_count_next;
  end

endmodule
